[design/segment_distance_3d_ternary_macros.svh]
// assertion macros for the segment distance block
// no dependencies
`ifndef SEGMENT_DISTANCE_3D_TERNARY_MACROS_SVH
`define SEGMENT_DISTANCE_3D_TERNARY_MACROS_SVH
`define SDT_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define SDT_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

[design/sdt_pkg.sv]
// shared types and constants for the segment distance block
// no dependencies
package sdt_pkg;
    localparam int COORD_W = 28;
    localparam int DIST_W = 29;
    localparam int EPS_W = 32;
    localparam int SQ_W = 61;
    localparam int MAX_STEPS_DEF = 96;
    localparam int FRAC_BITS_DEF = 16;
    typedef logic signed [COORD_W-1:0] t_coord;
    typedef struct packed {
        t_coord a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, a_end_z;
        t_coord b_start_x, b_start_y, b_start_z, b_end_x, b_end_y, b_end_z;
    } t_in_item;
    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              step_limit_hit;
    } t_out_item;
endpackage

[design/sdt_if.sv]
// valid/ready channel interfaces for the segment distance block
// depends on sdt_pkg
interface sdt_in_if import sdt_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sdt_out_if import sdt_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sdt_cfg_if import sdt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [EPS_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[design/segment_distance_3d_ternary.sv]
// segment distance top level: nested ternary search with one shared multiplier
// depends on sdt_pkg, sdt_if.sv and segment_distance_3d_ternary_macros.svh
//
// channel   dir  payload
// i_in      in   twelve Q11.16 end coordinates
// o_out     out  distance Q13.16, step_limit_hit
// i_cfg     in   eps_squared
//
// the 29x29 multiplier takes one square a cycle; a squared distance sums the three
// axes with the add folded in, and the result comes from a restoring square root.
// in-ready only in idle; a finished item holds in done while the output register
// is full; synchronous active-low reset clears control state.
`include "segment_distance_3d_ternary_macros.svh"
module segment_distance_3d_ternary
    import sdt_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sdt_in_if.sink     i_in,
    sdt_cfg_if.sink    i_cfg,
    sdt_out_if.source  o_out
);
    localparam int STEP_W = 8;
    localparam int DW = COORD_W + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_OCHK, S_OPROBE, S_ICHK, S_IPROBE, S_ICMP, S_IFIN,
        S_ODEC, S_ROOT, S_DONE
    } t_state;
    // what the measure unit computes
    typedef enum logic [1:0] {M_LEN, M_HI, M_LO, M_ANS} t_meas;
    // which inner search is running
    typedef enum logic [1:0] {P_HI, P_LO, P_FIN} t_pass;

    t_state r_state;
    t_meas  r_meas;
    t_pass  r_pass;
    logic [EPS_W-1:0] r_eps;
    t_coord r_oiv [6];
    t_coord r_iiv [6];
    t_coord r_b [6];
    t_coord r_op [6];
    logic [SQ_W-1:0] r_pd [2];
    logic [SQ_W-1:0] r_acc, r_sqhi;
    logic [1:0] r_k;
    logic [STEP_W-1:0] r_ostep, r_istep;
    logic r_flag;
    logic [63:0] r_rv, r_res, r_bit;
    logic r_ovalid;
    t_out_item r_odata;

    assign i_cfg.ready = (r_state == S_IDLE);
    assign i_in.ready = (r_state == S_IDLE);
    assign o_out.valid = r_ovalid;
    assign o_out.data = r_odata;

    function automatic t_coord hf(t_coord a, t_coord b);
        logic signed [COORD_W:0] s;
        s = $signed({a[COORD_W-1], a}) + $signed({b[COORD_W-1], b});
        return s[COORD_W:1];
    endfunction

    // low end and high end index of the current axis
    logic [2:0] w_lo_idx, w_hi_idx;
    assign w_lo_idx = {1'b0, r_k};
    assign w_hi_idx = 3'd3 + {1'b0, r_k};

    // probe point for the current axis index r_k
    t_coord w_pt;
    always_comb begin
        unique case (r_pass)
            P_HI:    w_pt = r_op[w_lo_idx];
            P_LO:    w_pt = r_op[w_hi_idx];
            default: w_pt = r_oiv[w_hi_idx];
        endcase
    end

    // shared squaring unit operands
    logic signed [DW-1:0] w_p, w_q, w_d;
    logic [DW-1:0] w_m;
    logic [2*DW-1:0] w_sq;
    t_coord w_m0, w_ph, w_pl;
    always_comb begin
        w_m0 = hf(r_iiv[w_lo_idx], r_iiv[w_hi_idx]);
        w_ph = hf(w_m0, r_iiv[w_hi_idx]);
        w_pl = hf(w_m0, r_iiv[w_lo_idx]);
        w_p = '0;
        w_q = '0;
        unique case (r_meas)
            M_LEN: begin
                if (r_state == S_OCHK) begin
                    w_p = DW'(r_oiv[w_lo_idx]);
                    w_q = DW'(r_oiv[w_hi_idx]);
                end else begin
                    w_p = DW'(r_iiv[w_lo_idx]);
                    w_q = DW'(r_iiv[w_hi_idx]);
                end
            end
            M_HI: begin
                w_p = DW'(w_ph);
                w_q = DW'(w_pt);
            end
            M_LO: begin
                w_p = DW'(w_pl);
                w_q = DW'(w_pt);
            end
            default: begin
                w_p = DW'(r_iiv[w_hi_idx]);
                w_q = DW'(w_pt);
            end
        endcase
        w_d = w_p - w_q;
        w_m = w_d[DW-1] ? DW'(-w_d) : DW'(w_d);
        w_sq = w_m * w_m;
    end

    logic [SQ_W-1:0] n_acc;
    assign n_acc = r_acc + SQ_W'(w_sq);
    logic [63:0] w_trial;
    assign w_trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_eps <= EPS_W'(1);
            r_ovalid <= 1'b0;
            r_k <= '0;
            r_flag <= 1'b0;
            r_meas <= M_LEN;
            r_pass <= P_HI;
        end else begin
            if (o_out.valid && o_out.ready && r_state != S_DONE) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_cfg.valid) r_eps <= i_cfg.data;
                    if (i_in.valid) begin
                        r_oiv[0] <= i_in.data.a_start_x; r_oiv[1] <= i_in.data.a_start_y;
                        r_oiv[2] <= i_in.data.a_start_z; r_oiv[3] <= i_in.data.a_end_x;
                        r_oiv[4] <= i_in.data.a_end_y; r_oiv[5] <= i_in.data.a_end_z;
                        r_b[0] <= i_in.data.b_start_x; r_b[1] <= i_in.data.b_start_y;
                        r_b[2] <= i_in.data.b_start_z; r_b[3] <= i_in.data.b_end_x;
                        r_b[4] <= i_in.data.b_end_y; r_b[5] <= i_in.data.b_end_z;
                        r_flag <= 1'b0;
                        r_ostep <= '0;
                        r_k <= '0;
                        r_acc <= '0;
                        r_meas <= M_LEN;
                        r_state <= S_OCHK;
                    end
                end
                S_OCHK: begin
                    // outer interval length, one axis a cycle
                    if (r_k == 2'd2) begin
                        r_k <= '0;
                        r_acc <= '0;
                        if (n_acc <= SQ_W'(r_eps)) begin
                            r_pass <= P_FIN;
                            r_state <= S_OPROBE;
                        end else if (r_ostep >= STEP_W'(MAX_STEPS)) begin
                            r_flag <= 1'b1;
                            r_pass <= P_FIN;
                            r_state <= S_OPROBE;
                        end else begin
                            r_pass <= P_HI;
                            r_state <= S_OPROBE;
                        end
                    end else begin
                        r_acc <= n_acc;
                        r_k <= r_k + 2'd1;
                    end
                end
                S_OPROBE: begin
                    // place outer probes, then start the inner search
                    for (int k = 0; k < 3; k++) begin
                        r_op[k] <= hf(hf(r_oiv[k], r_oiv[3 + k]), r_oiv[3 + k]);
                        r_op[3 + k] <= hf(hf(r_oiv[k], r_oiv[3 + k]), r_oiv[k]);
                    end
                    for (int k = 0; k < 6; k++) r_iiv[k] <= r_b[k];
                    r_istep <= '0;
                    r_acc <= '0;
                    r_k <= '0;
                    r_meas <= M_LEN;
                    r_state <= S_ICHK;
                end
                S_ICHK: begin
                    if (r_k == 2'd2) begin
                        r_k <= '0;
                        r_acc <= '0;
                        if (n_acc <= SQ_W'(r_eps)) begin
                            r_meas <= M_ANS;
                            r_state <= S_IFIN;
                        end else if (r_istep >= STEP_W'(MAX_STEPS)) begin
                            r_flag <= 1'b1;
                            r_meas <= M_ANS;
                            r_state <= S_IFIN;
                        end else begin
                            r_meas <= M_HI;
                            r_state <= S_IPROBE;
                        end
                    end else begin
                        r_acc <= n_acc;
                        r_k <= r_k + 2'd1;
                    end
                end
                S_IPROBE: begin
                    if (r_k == 2'd2) begin
                        r_k <= '0;
                        if (r_meas == M_HI) begin
                            r_sqhi <= n_acc;
                            r_acc <= '0;
                            r_meas <= M_LO;
                        end else begin
                            r_acc <= n_acc;
                            r_state <= S_ICMP;
                        end
                    end else begin
                        r_acc <= n_acc;
                        r_k <= r_k + 2'd1;
                    end
                end
                S_ICMP: begin
                    for (int k = 0; k < 3; k++) begin
                        if (r_sqhi <= r_acc)
                            r_iiv[k] <= hf(hf(r_iiv[k], r_iiv[3 + k]), r_iiv[k]);
                        else
                            r_iiv[3 + k] <= hf(hf(r_iiv[k], r_iiv[3 + k]), r_iiv[3 + k]);
                    end
                    r_istep <= r_istep + STEP_W'(1);
                    r_acc <= '0;
                    r_meas <= M_LEN;
                    r_state <= S_ICHK;
                end
                S_IFIN: begin
                    if (r_k == 2'd2) begin
                        r_k <= '0;
                        r_acc <= '0;
                        unique case (r_pass)
                            P_HI: begin
                                r_pd[0] <= n_acc;
                                r_pass <= P_LO;
                                for (int k = 0; k < 6; k++) r_iiv[k] <= r_b[k];
                                r_istep <= '0;
                                r_meas <= M_LEN;
                                r_state <= S_ICHK;
                            end
                            P_LO: begin
                                r_pd[1] <= n_acc;
                                r_state <= S_ODEC;
                            end
                            default: begin
                                r_rv <= 64'(n_acc);
                                r_res <= '0;
                                r_bit <= 64'h4000_0000_0000_0000;
                                r_state <= S_ROOT;
                            end
                        endcase
                    end else begin
                        r_acc <= n_acc;
                        r_k <= r_k + 2'd1;
                    end
                end
                S_ODEC: begin
                    for (int k = 0; k < 3; k++) begin
                        if (r_pd[0] <= r_pd[1]) r_oiv[k] <= r_op[3 + k];
                        else r_oiv[3 + k] <= r_op[k];
                    end
                    r_ostep <= r_ostep + STEP_W'(1);
                    r_acc <= '0;
                    r_k <= '0;
                    r_meas <= M_LEN;
                    r_pass <= P_HI;
                    r_state <= S_OCHK;
                end
                S_ROOT: begin
                    // restoring root, one result bit a cycle
                    if (r_rv >= w_trial) begin
                        r_rv <= r_rv - w_trial;
                        r_res <= (r_res >> 1) + r_bit;
                    end else r_res <= r_res >> 1;
                    r_bit <= r_bit >> 2;
                    if (r_bit == 64'd1) r_state <= S_DONE;
                end
                default: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_odata.distance <= r_res[DIST_W-1:0];
                        r_odata.step_limit_hit <= r_flag;
                        r_ovalid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

    `SDT_ASSERT_IMP(a_busy_not_ready, i_clk, i_rst_n, r_state != S_IDLE, !i_in.ready)
    `SDT_ASSERT_IMP(a_ostep_bound, i_clk, i_rst_n, r_state == S_OPROBE, r_ostep <= STEP_W'(MAX_STEPS))
    `SDT_ASSERT_IMP(a_istep_bound, i_clk, i_rst_n, r_state == S_ICMP, r_istep < STEP_W'(MAX_STEPS))
    `SDT_ASSERT_NEXT(a_done_valid, i_clk, i_rst_n, r_state == S_DONE && (!r_ovalid || o_out.ready), o_out.valid)
endmodule

[tb/segment_distance_3d_ternary_tb.sv]
// testbench for segment_distance_3d_ternary: random and directed segment pairs,
// a built-in predictor of the nested ternary search and a result scoreboard
// depends on sdt_pkg, sdt_if.sv and the segment_distance_3d_ternary top level
`timescale 1ns / 100ps

module segment_distance_3d_ternary_tb;
    import sdt_pkg::*;

    localparam int STEP_LIMIT = MAX_STEPS_DEF;
    localparam int SETTLE_CYCLES = 100;

    typedef enum logic [1:0] {
        JOB_SEGMENTS,
        JOB_SET_EPS,
        JOB_DRAIN
    } t_job_kind;

    typedef struct {
        t_job_kind        kind;
        t_in_item         segs;
        logic [EPS_W-1:0] eps;
    } t_job;

    logic i_clk;
    logic i_rst_n;

    sdt_in_if  in_if ();
    sdt_cfg_if cfg_if ();
    sdt_out_if out_if ();

    segment_distance_3d_ternary u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    t_job              job_queue[$];
    t_out_item         expected_dist[$];
    logic [EPS_W-1:0]  eps_shadow;
    int                error_count = 0;
    int                send_gap;
    int                recv_gap;
    int                sent_count;
    int                recv_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------
    function automatic longint unsigned sq_len(input longint p[3], input longint q[3]);
        longint unsigned acc;
        longint d;
        acc = 0;
        for (int k = 0; k < 3; k++) begin
            d = p[k] - q[k];
            if (d < 0) d = -d;
            acc += longint'(d) * longint'(d);
        end
        return acc;
    endfunction

    // floor halving on sign-extended values
    function automatic longint mid_floor(input longint a, input longint b);
        return (a + b) >>> 1;
    endfunction

    function automatic void quarter_points(input longint lo[3], input longint hi[3],
                                           output longint near_hi[3],
                                           output longint near_lo[3]);
        longint m;
        for (int k = 0; k < 3; k++) begin
            m = mid_floor(lo[k], hi[k]);
            near_hi[k] = mid_floor(m, hi[k]);
            near_lo[k] = mid_floor(m, lo[k]);
        end
    endfunction

    function automatic longint unsigned point_to_seg(input longint b_lo[3],
                                                     input longint b_hi[3],
                                                     input longint pt[3],
                                                     input longint unsigned eps,
                                                     inout bit limit);
        longint lo[3], hi[3], ph[3], pl[3];
        int steps;
        lo = b_lo;
        hi = b_hi;
        steps = 0;
        while (sq_len(lo, hi) > eps) begin
            if (steps >= STEP_LIMIT) begin
                limit = 1'b1;
                break;
            end
            quarter_points(lo, hi, ph, pl);
            if (sq_len(ph, pt) <= sq_len(pl, pt)) lo = pl;
            else hi = ph;
            steps++;
        end
        return sq_len(hi, pt);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic t_out_item predict_distance(input t_in_item s,
                                                   input logic [EPS_W-1:0] eps_reg);
        longint a_lo[3], a_hi[3], b_lo[3], b_hi[3], ph[3], pl[3];
        longint unsigned eps, d_hi, d_lo, best;
        bit limit;
        int steps;
        t_out_item r;
        a_lo = '{longint'(s.a_start_x), longint'(s.a_start_y), longint'(s.a_start_z)};
        a_hi = '{longint'(s.a_end_x), longint'(s.a_end_y), longint'(s.a_end_z)};
        b_lo = '{longint'(s.b_start_x), longint'(s.b_start_y), longint'(s.b_start_z)};
        b_hi = '{longint'(s.b_end_x), longint'(s.b_end_y), longint'(s.b_end_z)};
        eps = longint'(eps_reg);
        limit = 1'b0;
        steps = 0;
        while (sq_len(a_lo, a_hi) > eps) begin
            if (steps >= STEP_LIMIT) begin
                limit = 1'b1;
                break;
            end
            quarter_points(a_lo, a_hi, ph, pl);
            d_hi = point_to_seg(b_lo, b_hi, ph, eps, limit);
            d_lo = point_to_seg(b_lo, b_hi, pl, eps, limit);
            if (d_hi <= d_lo) a_lo = pl;
            else a_hi = ph;
            steps++;
        end
        best = point_to_seg(b_lo, b_hi, a_hi, eps, limit);
        r.distance = DIST_W'(int_sqrt(best));
        r.step_limit_hit = limit;
        return r;
    endfunction

    // ---------------- stimulus ----------------
    function automatic t_coord rand_coord(input bit full_range);
        if (full_range) return t_coord'($urandom());
        return t_coord'($signed($urandom_range(0, 8191)) - 4096);
    endfunction

    function automatic t_in_item rand_segments();
        t_in_item s;
        bit full;
        full = ($urandom_range(0, 9) < 3);
        s = '{default: '0};
        s.a_start_x = rand_coord(full); s.a_start_y = rand_coord(full);
        s.a_start_z = rand_coord(full); s.a_end_x = rand_coord(full);
        s.a_end_y = rand_coord(full);   s.a_end_z = rand_coord(full);
        s.b_start_x = rand_coord(full); s.b_start_y = rand_coord(full);
        s.b_start_z = rand_coord(full); s.b_end_x = rand_coord(full);
        s.b_end_y = rand_coord(full);   s.b_end_z = rand_coord(full);
        // occasional point-like segments
        case ($urandom_range(0, 9))
            0: begin
                s.a_end_x = s.a_start_x; s.a_end_y = s.a_start_y; s.a_end_z = s.a_start_z;
            end
            1: begin
                s.b_end_x = s.b_start_x; s.b_end_y = s.b_start_y; s.b_end_z = s.b_start_z;
            end
            default: ;
        endcase
        return s;
    endfunction

    function automatic t_in_item make_segments(input longint ax0, ay0, az0, ax1, ay1, az1,
                                               input longint bx0, by0, bz0, bx1, by1, bz1);
        t_in_item s;
        s.a_start_x = t_coord'(ax0); s.a_start_y = t_coord'(ay0); s.a_start_z = t_coord'(az0);
        s.a_end_x = t_coord'(ax1);   s.a_end_y = t_coord'(ay1);   s.a_end_z = t_coord'(az1);
        s.b_start_x = t_coord'(bx0); s.b_start_y = t_coord'(by0); s.b_start_z = t_coord'(bz0);
        s.b_end_x = t_coord'(bx1);   s.b_end_y = t_coord'(by1);   s.b_end_z = t_coord'(bz1);
        return s;
    endfunction

    task automatic push_segments(input t_in_item s);
        t_job j;
        j.kind = JOB_SEGMENTS;
        j.segs = s;
        j.eps = '0;
        job_queue.push_back(j);
    endtask

    task automatic push_eps(input logic [EPS_W-1:0] v);
        t_job j;
        j.kind = JOB_SET_EPS;
        j.segs = '{default: '0};
        j.eps = v;
        job_queue.push_back(j);
    endtask

    task automatic push_drain();
        t_job j;
        j.kind = JOB_DRAIN;
        j.segs = '{default: '0};
        j.eps = '0;
        job_queue.push_back(j);
    endtask

    initial begin
        longint mx, mn;
        mx = 134217727;
        mn = -134217728;
        // directed, reset threshold
        push_segments(make_segments(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        push_segments(make_segments(mx, mx, mx, mx, mx, mx, mn, mn, mn, mn, mn, mn));
        push_segments(make_segments(mn, mn, mn, mx, mx, mx, mx, mn, mx, mn, mx, mn));
        push_segments(make_segments(mx, mn, mx, mn, mx, mn, mx, mx, mx, mx, mx, mx));
        push_segments(make_segments(-65536, 0, 0, 65536, 0, 0, 0, -65536, 0, 0, 65536, 0));
        push_segments(make_segments(0, 0, 0, 655360, 0, 0, 0, 65536, 0, 655360, 65536, 0));
        push_segments(make_segments(100, 200, 300, 100, 200, 300, -50, 7, 9, 4000, -3, 12));
        push_segments(make_segments(-5, 5, 0, 5, -5, 0, 1000, 1000, 1000, 1000, 1000, 1000));
        // symmetric case: both probes see the same distance
        push_segments(make_segments(-4096, 0, 0, 4096, 0, 0, 0, 0, 8192, 0, 0, 8192));
        push_segments(make_segments(1, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1));
        push_segments(make_segments(mn, 0, 0, mn, 0, 1, mx, 0, 0, mx, 1, 0));
        for (int i = 0; i < 30; i++) push_segments(rand_segments());
        push_drain();
        for (int i = 0; i < 5; i++) push_segments(rand_segments());
        // zero threshold: one-LSB intervals run into the step limit
        push_eps('0);
        push_segments(make_segments(0, 0, 0, 1, 0, 0, 5, 5, 5, 6, 5, 5));
        push_segments(make_segments(mn, mn, mn, mx, mx, mx, mx, mn, mn, mn, mx, mx));
        for (int i = 0; i < 4; i++) push_segments(rand_segments());
        push_eps('1);
        push_segments(make_segments(mn, mn, mn, mx, mx, mx, 0, 0, 0, 7, 7, 7));
        for (int i = 0; i < 10; i++) push_segments(rand_segments());
        push_eps($urandom());
        for (int i = 0; i < 15; i++) push_segments(rand_segments());
        push_eps(EPS_W'($urandom_range(2, 5000)));
        for (int i = 0; i < 20; i++) push_segments(rand_segments());
        push_eps(32'd1);
        for (int i = 0; i < 15; i++) push_segments(rand_segments());
    end

    // ---------------- driver ----------------
    always @(posedge i_clk) begin
        logic in_v, cfg_v;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            in_if.data <= '0;
            cfg_if.valid <= 1'b0;
            cfg_if.data <= '0;
            send_gap <= 0;
            sent_count <= 0;
            eps_shadow <= 32'd1;
        end else begin
            in_v = in_if.valid;
            cfg_v = cfg_if.valid;
            if (in_if.valid && in_if.ready) begin
                in_v = 1'b0;
                expected_dist.push_back(predict_distance(in_if.data, eps_shadow));
                sent_count <= sent_count + 1;
            end
            if (cfg_if.valid && cfg_if.ready) begin
                cfg_v = 1'b0;
                eps_shadow <= cfg_if.data;
            end
            if (!in_v && !cfg_v) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                end else if (job_queue.size() > 0) begin
                    case (job_queue[0].kind)
                        JOB_SEGMENTS: begin
                            in_v = 1'b1;
                            in_if.data <= job_queue[0].segs;
                            void'(job_queue.pop_front());
                            // every third block of 16 transactions runs with no gaps
                            send_gap <= ((sent_count / 16) % 3 == 2) ? 0 : $urandom_range(0, 9);
                        end
                        JOB_SET_EPS: begin
                            if (expected_dist.size() == 0) begin
                                cfg_v = 1'b1;
                                cfg_if.data <= job_queue[0].eps;
                                void'(job_queue.pop_front());
                            end
                        end
                        default: begin
                            if (expected_dist.size() == 0) void'(job_queue.pop_front());
                        end
                    endcase
                end
            end
            in_if.valid <= in_v;
            cfg_if.valid <= cfg_v;
        end
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        logic rdy;
        t_out_item want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            recv_gap <= 0;
            recv_count <= 0;
        end else begin
            rdy = out_if.ready;
            if (out_if.valid && out_if.ready) begin
                rdy = 1'b0;
                recv_count <= recv_count + 1;
                recv_gap <= ((recv_count / 16) % 3 == 1) ? 0 : $urandom_range(0, 9);
                if (expected_dist.size() == 0) begin
                    $display("%0t: unexpected result distance=%0d limit=%0b", $time,
                             out_if.data.distance, out_if.data.step_limit_hit);
                    error_count++;
                end else begin
                    want = expected_dist.pop_front();
                    if (out_if.data.distance !== want.distance) begin
                        $display("%0t: distance mismatch expected %0d actual %0d", $time,
                                 want.distance, out_if.data.distance);
                        error_count++;
                    end
                    if (out_if.data.step_limit_hit !== want.step_limit_hit) begin
                        $display("%0t: step_limit_hit mismatch expected %0b actual %0b",
                                 $time, want.step_limit_hit, out_if.data.step_limit_hit);
                        error_count++;
                    end
                end
            end else if (!rdy) begin
                if (recv_gap > 0) recv_gap <= recv_gap - 1;
                else rdy = 1'b1;
            end
            out_if.ready <= rdy;
        end
    end

    // ---------------- sequencing ----------------
    initial begin
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (job_queue.size() > 0 || in_if.valid || cfg_if.valid || expected_dist.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #1_000_000_000;
        $display("%0t: timeout", $time);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

[sim.f]
+incdir+design
design/sdt_pkg.sv
design/sdt_if.sv
design/segment_distance_3d_ternary.sv
tb/segment_distance_3d_ternary_tb.sv
